// ===== sv/ezt_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Z-Y-X Euler transform.
// No dependencies; every other file imports this package.
package ezt_pkg;

   localparam int ANGLE_WIDTH  = 16;
   localparam int ENTRY_WIDTH  = 16;
   localparam int OFFSET_WIDTH = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int CW           = 34;   // CORDIC datapath width, Q.30 with headroom
   localparam int QW           = 32;   // clamped sine/cosine and products, Q.30
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int MATRIX_LAT   = 3;
   localparam int TOTAL_LAT    = CORDIC_LAT + MATRIX_LAT;
   localparam int ENTRY_SHIFT  = QW - ENTRY_WIDTH;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;

   localparam logic signed [CW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   localparam logic signed [QW+1:0] ENTRY_ROUND = (ENTRY_SHIFT > 0) ?
      ((QW+2)'(1) <<< ((ENTRY_SHIFT > 0) ? ENTRY_SHIFT - 1 : 0)) : '0;
   localparam logic signed [QW+1:0] ENTRY_ONE = (QW+2)'(1) <<< (ENTRY_WIDTH - 2);

   typedef logic signed [ANGLE_WIDTH-1:0]  angle_type;
   typedef logic signed [QW-1:0]           q30_type;
   typedef logic signed [ENTRY_WIDTH-1:0]  entry_type;
   typedef logic signed [OFFSET_WIDTH-1:0] offset_type;

   typedef struct packed {
      offset_type x;
      offset_type y;
      offset_type z;
   } trans_type;

   // Q.30 product, rounded half up by floor shift
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + 64'sd536870912;
      p = p >>> 30;
      return p[QW-1:0];
   endfunction

   // Round a Q.30 sum to the entry format and saturate at plus or minus one
   function automatic entry_type to_entry(input logic signed [QW:0] v);
      logic signed [QW+1:0] r;
      r = (QW+2)'(v);
      r = (r + ENTRY_ROUND) >>> ENTRY_SHIFT;
      if (r > ENTRY_ONE) r = ENTRY_ONE;
      if (r < -ENTRY_ONE) r = -ENTRY_ONE;
      return r[ENTRY_WIDTH-1:0];
   endfunction

endpackage

// ===== sv/ezt_if.sv =====
// Valid/ready channel interfaces for pose requests and transform responses.
// Depends on ezt_pkg for field types.
interface ezt_req_if;
   import ezt_pkg::*;
   logic       valid;
   logic       ready;
   angle_type  yaw_angle;
   angle_type  pitch_angle;
   angle_type  roll_angle;
   offset_type offset_x;
   offset_type offset_y;
   offset_type offset_z;
   modport source (output valid, yaw_angle, pitch_angle, roll_angle,
                   offset_x, offset_y, offset_z, input ready);
   modport sink   (input valid, yaw_angle, pitch_angle, roll_angle,
                   offset_x, offset_y, offset_z, output ready);
endinterface

interface ezt_rsp_if;
   import ezt_pkg::*;
   logic       valid;
   logic       ready;
   entry_type  m00, m01, m02, m10, m11, m12, m20, m21, m22;
   offset_type trans_x;
   offset_type trans_y;
   offset_type trans_z;
   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   trans_x, trans_y, trans_z, input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   trans_x, trans_y, trans_z, output ready);
endinterface

// ===== sv/euler_zyx_homogeneous_transform.sv =====
// Z-Y-X Euler angles plus translation to the top three rows of a homogeneous transform.
// Pipeline: 26 CORDIC stages, then 3 product/sum stages, from request to response.
// Throughput: one item per cycle; the whole pipeline holds while a response waits.
// Reset: synchronous, active high; clears the valid bits, data registers are not reset.
// Depends on ezt_pkg, ezt_if, ezt_cordic and ezt_matrix.
module euler_zyx_homogeneous_transform (
   input  logic   clock,
   input  logic   reset,
   ezt_req_if.sink   req_chan,
   ezt_rsp_if.source rsp_chan
);
   import ezt_pkg::*;

   logic                 advance;
   logic [TOTAL_LAT-1:0] valid_ff;
   trans_type            trans_ff [TOTAL_LAT];
   q30_type              sy, cy, sp, cp, sr, cr;

   // advance when the output stage is empty or being drained
   assign advance        = !valid_ff[TOTAL_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[TOTAL_LAT-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trans_ff[0] <= '{x: req_chan.offset_x, y: req_chan.offset_y,
                          z: req_chan.offset_z};
         for (int i = 1; i < TOTAL_LAT; i++) begin
            trans_ff[i] <= trans_ff[i-1];
         end
      end
   end

   ezt_cordic u_yaw (
      .clock(clock), .advance(advance), .angle(req_chan.yaw_angle),
      .sin_out(sy), .cos_out(cy)
   );
   ezt_cordic u_pitch (
      .clock(clock), .advance(advance), .angle(req_chan.pitch_angle),
      .sin_out(sp), .cos_out(cp)
   );
   ezt_cordic u_roll (
      .clock(clock), .advance(advance), .angle(req_chan.roll_angle),
      .sin_out(sr), .cos_out(cr)
   );

   ezt_matrix u_matrix (
      .clock(clock), .advance(advance),
      .sy(sy), .cy(cy), .sp(sp), .cp(cp), .sr(sr), .cr(cr),
      .m00(rsp_chan.m00), .m01(rsp_chan.m01), .m02(rsp_chan.m02),
      .m10(rsp_chan.m10), .m11(rsp_chan.m11), .m12(rsp_chan.m12),
      .m20(rsp_chan.m20), .m21(rsp_chan.m21), .m22(rsp_chan.m22)
   );

   assign rsp_chan.valid   = valid_ff[TOTAL_LAT-1];
   assign rsp_chan.trans_x = trans_ff[TOTAL_LAT-1].x;
   assign rsp_chan.trans_y = trans_ff[TOTAL_LAT-1].y;
   assign rsp_chan.trans_z = trans_ff[TOTAL_LAT-1].z;

`ifndef SYNTH
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");
   a_m00_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.m00 <= entry_type'(ENTRY_ONE)) &&
                         (rsp_chan.m00 >= -entry_type'(ENTRY_ONE)))
      else $error("m00 out of range");
   a_m11_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.m11 <= entry_type'(ENTRY_ONE)) &&
                         (rsp_chan.m11 >= -entry_type'(ENTRY_ONE)))
      else $error("m11 out of range");
   a_stall_holds_pipe : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(valid_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

// ===== sv/ezt_cordic.sv =====
// Pipelined rotation-mode CORDIC: one iteration per register stage.
// Gives clamped Q.30 sine and cosine of a binary angle. Depends on ezt_pkg.
module ezt_cordic (
   input  logic               clock,
   input  logic               advance,
   input  ezt_pkg::angle_type angle,
   output ezt_pkg::q30_type   sin_out,
   output ezt_pkg::q30_type   cos_out
);
   import ezt_pkg::*;

   logic signed [CW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS+1];
   logic                 flip_ff [CORDIC_STEPS+1];
   q30_type              sin_ff, cos_ff;

   logic [31:0] turn_in;
   logic [31:0] probe_in;
   logic        flip_in;
   logic [31:0] turn_fold_in;

   // Fold angles in the left half-plane by pi and negate at the end
   always_comb begin
      turn_in      = {angle, {(32-ANGLE_WIDTH){1'b0}}};
      probe_in     = turn_in + 32'h4000_0000;
      flip_in      = probe_in[31];
      turn_fold_in = flip_in ? (turn_in + 32'h8000_0000) : turn_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CW'(signed'(turn_fold_in));
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   logic signed [CW-1:0] x_in, y_in;

   always_comb begin
      x_in = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
      y_in = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      if (x_in > Q30_ONE)  x_in = Q30_ONE;
      if (x_in < -Q30_ONE) x_in = -Q30_ONE;
      if (y_in > Q30_ONE)  y_in = Q30_ONE;
      if (y_in < -Q30_ONE) y_in = -Q30_ONE;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= x_in[QW-1:0];
         sin_ff <= y_in[QW-1:0];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== sv/ezt_matrix.sv =====
// Three-stage product and sum pipeline that forms the nine rotation entries.
// Takes Q.30 sines and cosines from ezt_cordic; depends on ezt_pkg.
module ezt_matrix (
   input  logic               clock,
   input  logic               advance,
   input  ezt_pkg::q30_type   sy,
   input  ezt_pkg::q30_type   cy,
   input  ezt_pkg::q30_type   sp,
   input  ezt_pkg::q30_type   cp,
   input  ezt_pkg::q30_type   sr,
   input  ezt_pkg::q30_type   cr,
   output ezt_pkg::entry_type m00,
   output ezt_pkg::entry_type m01,
   output ezt_pkg::entry_type m02,
   output ezt_pkg::entry_type m10,
   output ezt_pkg::entry_type m11,
   output ezt_pkg::entry_type m12,
   output ezt_pkg::entry_type m20,
   output ezt_pkg::entry_type m21,
   output ezt_pkg::entry_type m22
);
   import ezt_pkg::*;

   // first products
   q30_type cysp_ff, sysp_ff, cycp_ff, sycp_ff, cpsr_ff, cpcr_ff;
   q30_type sycr_ff, sysr_ff, cycr_ff, cysr_ff, sr1_ff, cr1_ff, sp1_ff;
   // second products
   q30_type t1_ff, t2_ff, t3_ff, t4_ff;
   q30_type cycp2_ff, sycp2_ff, cpsr2_ff, cpcr2_ff;
   q30_type sycr2_ff, sysr2_ff, cycr2_ff, cysr2_ff, sp2_ff;
   entry_type m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff, m20_ff, m21_ff, m22_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         cysp_ff <= qmul(cy, sp);
         sysp_ff <= qmul(sy, sp);
         cycp_ff <= qmul(cy, cp);
         sycp_ff <= qmul(sy, cp);
         cpsr_ff <= qmul(cp, sr);
         cpcr_ff <= qmul(cp, cr);
         sycr_ff <= qmul(sy, cr);
         sysr_ff <= qmul(sy, sr);
         cycr_ff <= qmul(cy, cr);
         cysr_ff <= qmul(cy, sr);
         sr1_ff  <= sr;
         cr1_ff  <= cr;
         sp1_ff  <= sp;

         t1_ff    <= qmul(cysp_ff, sr1_ff);
         t2_ff    <= qmul(cysp_ff, cr1_ff);
         t3_ff    <= qmul(sysp_ff, sr1_ff);
         t4_ff    <= qmul(sysp_ff, cr1_ff);
         cycp2_ff <= cycp_ff;
         sycp2_ff <= sycp_ff;
         cpsr2_ff <= cpsr_ff;
         cpcr2_ff <= cpcr_ff;
         sycr2_ff <= sycr_ff;
         sysr2_ff <= sysr_ff;
         cycr2_ff <= cycr_ff;
         cysr2_ff <= cysr_ff;
         sp2_ff   <= sp1_ff;

         m00_ff <= to_entry((QW+1)'(cycp2_ff));
         m01_ff <= to_entry((QW+1)'(t1_ff) - (QW+1)'(sycr2_ff));
         m02_ff <= to_entry((QW+1)'(t2_ff) + (QW+1)'(sysr2_ff));
         m10_ff <= to_entry((QW+1)'(sycp2_ff));
         m11_ff <= to_entry((QW+1)'(t3_ff) + (QW+1)'(cycr2_ff));
         m12_ff <= to_entry((QW+1)'(t4_ff) - (QW+1)'(cysr2_ff));
         m20_ff <= to_entry(-(QW+1)'(sp2_ff));
         m21_ff <= to_entry((QW+1)'(cpsr2_ff));
         m22_ff <= to_entry((QW+1)'(cpcr2_ff));
      end
   end

   assign m00 = m00_ff;
   assign m01 = m01_ff;
   assign m02 = m02_ff;
   assign m10 = m10_ff;
   assign m11 = m11_ff;
   assign m12 = m12_ff;
   assign m20 = m20_ff;
   assign m21 = m21_ff;
   assign m22 = m22_ff;

endmodule
